>>> rtl/core/qrs_pkg.sv
package qrs_pkg;

	// Word and fraction widths of the coefficients and roots.
	localparam int W = 32;
	localparam int F = 16;

	// Discriminant magnitude, square root and its partial remainder.
	localparam int DW = 2 * W + 2;
	localparam int RW = DW / 2;
	localparam int RMW = RW + 3;

	// Divider: numerator magnitude, shifted numerator, divisor, remainder.
	localparam int NW = W + 2;
	localparam int NSW = NW + F;
	localparam int DENW = W + 1;
	localparam int REMW = DENW + 1;

	localparam logic [1:0] MODE_QUAD = 2'd0;
	localparam logic [1:0] MODE_LIN  = 2'd1;

	localparam logic [2:0] KIND_REAL   = 3'd0;
	localparam logic [2:0] KIND_DOUBLE = 3'd1;
	localparam logic [2:0] KIND_CPLX   = 3'd2;
	localparam logic [2:0] KIND_LIN    = 3'd3;
	localparam logic [2:0] KIND_ALL    = 3'd4;
	localparam logic [2:0] KIND_DIVZ   = 3'd5;

	typedef struct packed {
		logic [1:0]          mode;
		logic signed [W-1:0] coef_a;
		logic signed [W-1:0] coef_b;
		logic signed [W-1:0] coef_c;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic signed [W-1:0] root_real;
		logic signed [W-1:0] root_imag;
		logic                saturated;
		logic                last;
	} out_item_t;

	// Sideband that rides along the square root pipeline.
	typedef struct packed {
		logic [2:0]      kind;
		logic [DENW-1:0] den;
		logic [W-1:0]    num0;
		logic            neg0;
		logic            nb;
		logic            sa;
	} side_t;

	// Both quotients of one item after saturation.
	typedef struct packed {
		logic [2:0]   kind;
		logic [W-1:0] qa;
		logic         sat_a;
		logic [W-1:0] qb;
		logic         sat_b;
	} quot_t;

	typedef struct packed {
		logic          s;
		logic [NW-1:0] m;
	} smag_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// Sign-magnitude addition; a zero result is positive.
	function automatic smag_t sm_add(input logic sx, input logic [NW-1:0] mx,
		input logic sy, input logic [NW-1:0] my);
		smag_t r;
		if (sx == sy) begin
			r.m = mx + my;
			r.s = sx;
		end else if (mx >= my) begin
			r.m = mx - my;
			r.s = sx;
		end else begin
			r.m = my - mx;
			r.s = sy;
		end
		if (r.m == '0) begin
			r.s = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/qrs_front.sv
module qrs_front
	import qrs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  in_item_t        in_item,
	output logic            out_valid,
	output logic [DW-1:0]   out_dmag,
	output side_t           out_side
);

	logic           v_s1, v_s2, v_s3;
	logic [1:0]     mode_s1, mode_s2;
	logic [W-1:0]   ma_s1, mb_s1, mc_s1, ma_s2, mb_s2, mc_s2;
	logic           sa_s1, sb_s1, sc_s1, sa_s2, sb_s2, sc_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [DW-1:0]  dmag_s3;
	side_t          side_s3;

	logic [DW-1:0]  bbx, ac4, dm;
	logic           dpos, dzero, nb;
	side_t          side_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_item.mode;
			ma_s1   <= mag(in_item.coef_a);
			mb_s1   <= mag(in_item.coef_b);
			mc_s1   <= mag(in_item.coef_c);
			sa_s1   <= in_item.coef_a[W-1];
			sb_s1   <= in_item.coef_b[W-1];
			sc_s1   <= in_item.coef_c[W-1];

			mode_s2 <= mode_s1;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			mc_s2   <= mc_s1;
			sa_s2   <= sa_s1;
			sb_s2   <= sb_s1;
			sc_s2   <= sc_s1;
			bb_s2   <= (2*W)'(mb_s1) * (2*W)'(mb_s1);
			ac_s2   <= (2*W)'(ma_s1) * (2*W)'(mc_s1);

			dmag_s3 <= dm;
			side_s3 <= side_c;
		end
	end

	assign bbx = {2'b00, bb_s2};
	assign ac4 = {ac_s2, 2'b00};
	assign nb  = !sb_s2 && (mb_s2 != '0);

	always_comb begin
		dm    = bbx;
		dzero = (bb_s2 == '0);
		dpos  = !dzero;
		if (ac_s2 != '0) begin
			if (sa_s2 != sc_s2) begin
				dm    = bbx + ac4;
				dzero = 1'b0;
				dpos  = 1'b1;
			end else if (bbx >= ac4) begin
				dm    = bbx - ac4;
				dzero = (bbx == ac4);
				dpos  = !dzero;
			end else begin
				dm    = ac4 - bbx;
				dzero = 1'b0;
				dpos  = 1'b0;
			end
		end
	end

	always_comb begin
		side_c.nb = nb;
		side_c.sa = sa_s2;
		case (mode_s2)
			MODE_QUAD: begin
				if (ma_s2 == '0) begin
					side_c.kind = KIND_DIVZ;
				end else if (dzero) begin
					side_c.kind = KIND_DOUBLE;
				end else if (dpos) begin
					side_c.kind = KIND_REAL;
				end else begin
					side_c.kind = KIND_CPLX;
				end
				side_c.den  = {ma_s2, 1'b0};
				side_c.num0 = mb_s2;
				side_c.neg0 = nb != sa_s2;
			end
			MODE_LIN: begin
				side_c.kind = (mb_s2 == '0) ? KIND_DIVZ : KIND_LIN;
				side_c.den  = {1'b0, mb_s2};
				side_c.num0 = mc_s2;
				side_c.neg0 = sc_s2 == sb_s2;
			end
			default: begin
				side_c.kind = KIND_ALL;
				side_c.den  = {1'b0, mb_s2};
				side_c.num0 = mc_s2;
				side_c.neg0 = 1'b0;
			end
		endcase
	end

	assign out_valid = v_s3;
	assign out_dmag  = dmag_s3;
	assign out_side  = side_s3;

endmodule

>>> rtl/core/qrs_sqrt.sv
module qrs_sqrt
	import qrs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rad,
	input  side_t         in_side,
	output logic          out_valid,
	output logic [RW-1:0] out_root,
	output side_t         out_side
);

	// One root bit per stage, two radicand bits consumed per stage.
	logic           v_s    [RW];
	logic [RMW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [DW-1:0]  x_s    [RW];
	side_t          side_s [RW];

	logic           p_v    [RW];
	logic [RMW-1:0] p_rem  [RW];
	logic [RW-1:0]  p_root [RW];
	logic [DW-1:0]  p_x    [RW];
	side_t          p_side [RW];

	assign p_v[0]    = in_valid;
	assign p_rem[0]  = '0;
	assign p_root[0] = '0;
	assign p_x[0]    = in_rad;
	assign p_side[0] = in_side;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RMW-1:0] cur, trial;

		if (k > 0) begin : g_link
			assign p_v[k]    = v_s[k-1];
			assign p_rem[k]  = rem_s[k-1];
			assign p_root[k] = root_s[k-1];
			assign p_x[k]    = x_s[k-1];
			assign p_side[k] = side_s[k-1];
		end

		assign cur   = {p_rem[k][RMW-3:0], p_x[k][DW-1 -: 2]};
		assign trial = {1'b0, p_root[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= p_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[k]  <= cur - trial;
					root_s[k] <= {p_root[k][RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {p_root[k][RW-2:0], 1'b0};
				end
				x_s[k]    <= {p_x[k][DW-3:0], 2'b00};
				side_s[k] <= p_side[k];
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

>>> rtl/core/qrs_div.sv
module qrs_div
	import qrs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RW-1:0] in_root,
	input  side_t         in_side,
	output logic          out_valid,
	output quot_t         out_quot
);

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [W-1:0]    low;
		logic [W-1:0]    q;
		logic            ovf;
		logic            neg;
	} lane_t;

	// Numerator setup: sign-magnitude sums for two distinct real roots, else num0 and the root.
	logic          v_s0;
	logic [2:0]    kind_s0;
	logic [DENW-1:0] den_s0;
	logic [NW-1:0] na_s0, nb_s0;
	logic          ga_s0, gb_s0;

	logic [NW-1:0] na_c, nb_c;
	logic          ga_c, gb_c;
	smag_t         t1, t2;

	assign t1 = sm_add(in_side.nb, NW'(in_side.num0), 1'b1, NW'(in_root));
	assign t2 = sm_add(in_side.nb, NW'(in_side.num0), 1'b0, NW'(in_root));

	always_comb begin
		if (in_side.kind == KIND_REAL) begin
			na_c = t1.m;
			ga_c = t1.s != in_side.sa;
			nb_c = t2.m;
			gb_c = t2.s != in_side.sa;
		end else begin
			na_c = NW'(in_side.num0);
			ga_c = in_side.neg0;
			nb_c = NW'(in_root);
			gb_c = 1'b0;
		end
	end

	// Quotient lanes: index 0 holds the overflow check, then one bit per stage.
	logic            v_s    [W+1];
	logic [2:0]      kind_s [W+1];
	logic [DENW-1:0] den_s  [W+1];
	lane_t           a_s    [W+1];
	lane_t           b_s    [W+1];

	logic            v_s2;
	quot_t           quot_s2;

	function automatic lane_t lane_init(input logic [NW-1:0] num, input logic neg,
		input logic [DENW-1:0] den);
		lane_t l;
		logic [NSW-1:0] n;
		n       = {num, {F{1'b0}}};
		l.rem   = REMW'(n[NSW-1:W]);
		l.low   = n[W-1:0];
		l.q     = '0;
		l.ovf   = REMW'(n[NSW-1:W]) >= {1'b0, den};
		l.neg   = neg;
		return l;
	endfunction

	function automatic lane_t lane_step(input lane_t l, input logic [DENW-1:0] den);
		lane_t r;
		logic [REMW-1:0] cur;
		r   = l;
		cur = {l.rem[REMW-2:0], l.low[W-1]};
		r.low = {l.low[W-2:0], 1'b0};
		if (cur >= {1'b0, den}) begin
			r.rem = cur - {1'b0, den};
			r.q   = {l.q[W-2:0], 1'b1};
		end else begin
			r.rem = cur;
			r.q   = {l.q[W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Clip to the signed range, then apply the sign.
	function automatic logic [W:0] lane_final(input lane_t l);
		logic [W-1:0] lim, val;
		logic         sat;
		lim = {1'b0, {(W-1){1'b1}}} + W'(l.neg);
		sat = l.ovf || (l.q > lim);
		val = sat ? lim : l.q;
		return {sat, l.neg ? (~val + 1'b1) : val};
	endfunction

	logic [W:0] fa, fb;

	assign fa = lane_final(a_s[W]);
	assign fb = lane_final(b_s[W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s[0] <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
			v_s[0] <= v_s0;
			v_s2 <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s0 <= in_side.kind;
			den_s0  <= in_side.den;
			na_s0   <= na_c;
			nb_s0   <= nb_c;
			ga_s0   <= ga_c;
			gb_s0   <= gb_c;

			kind_s[0] <= kind_s0;
			den_s[0]  <= den_s0;
			a_s[0]    <= lane_init(na_s0, ga_s0, den_s0);
			b_s[0]    <= lane_init(nb_s0, gb_s0, den_s0);

			quot_s2.kind  <= kind_s[W];
			quot_s2.qa    <= fa[W-1:0];
			quot_s2.sat_a <= fa[W];
			quot_s2.qb    <= fb[W-1:0];
			quot_s2.sat_b <= fb[W];
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				kind_s[k+1] <= kind_s[k];
				den_s[k+1]  <= den_s[k];
				a_s[k+1]    <= lane_step(a_s[k], den_s[k]);
				b_s[k+1]    <= lane_step(b_s[k], den_s[k]);
			end
		end
	end

	assign out_valid = v_s2;
	assign out_quot  = quot_s2;

endmodule

>>> rtl/core/quadratic_root_solver.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-------------------------------------
// item     | item_valid / item_ready      | in_item_t: mode, coef_a..coef_c
// result   | result_valid / result_ready  | out_item_t: kind, root, sat, last
//
// From an accepted item to its first result there are 3 front stages
// (magnitudes, the two 32x32 products, discriminant), 33 square root stages, 35
// divider stages and the output register. An item may enter every cycle while
// the pipeline is not stalled; a two-result item holds the output register
// until both results are taken and stalls the items behind it. Reset clears
// only the valid bits and the output index. Any stall freezes the whole pipeline.
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	// The pipeline moves as one: it advances whenever the output register is
	// empty or is handing over its final result in this cycle.
	logic          en;
	logic          pop_last;

	logic          f_valid;
	logic [DW-1:0] f_dmag;
	side_t         f_side;

	logic          r_valid;
	logic [RW-1:0] r_root;
	side_t         r_side;

	logic          d_valid;
	quot_t         d_quot;

	// Output register: one item, up to two results, idx_q picks which is shown.
	logic          hold_q;
	logic          idx_q;
	logic          two_q;
	logic [2:0]    kind_q;
	logic [W-1:0]  re0_q, im0_q, re1_q, im1_q;
	logic          sat0_q, sat1_q;

	assign pop_last   = hold_q && result_ready && (!two_q || idx_q);
	assign en         = !hold_q || pop_last;
	assign item_ready = en;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.in_item   (item),
		.out_valid (f_valid),
		.out_dmag  (f_dmag),
		.out_side  (f_side)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_rad    (f_dmag),
		.in_side   (f_side),
		.out_valid (r_valid),
		.out_root  (r_root),
		.out_side  (r_side)
	);

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.in_root   (r_root),
		.in_side   (r_side),
		.out_valid (d_valid),
		.out_quot  (d_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (en) begin
			hold_q <= d_valid;
			idx_q  <= 1'b0;
		end else if (result_ready) begin
			// First of two results taken; show the second one next.
			idx_q <= 1'b1;
		end
	end

	// Lay out the result pair. The complex pair shares its real part and the
	// second one carries the conjugate; rootless kinds report zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= d_quot.kind;
			re0_q  <= '0;
			im0_q  <= '0;
			sat0_q <= 1'b0;
			re1_q  <= '0;
			im1_q  <= '0;
			sat1_q <= 1'b0;
			two_q  <= 1'b0;
			case (d_quot.kind)
				KIND_REAL: begin
					re0_q  <= d_quot.qa;
					sat0_q <= d_quot.sat_a;
					re1_q  <= d_quot.qb;
					sat1_q <= d_quot.sat_b;
					two_q  <= 1'b1;
				end
				KIND_CPLX: begin
					re0_q  <= d_quot.qa;
					im0_q  <= d_quot.qb;
					sat0_q <= d_quot.sat_a || d_quot.sat_b;
					re1_q  <= d_quot.qa;
					im1_q  <= ~d_quot.qb + 1'b1;
					sat1_q <= d_quot.sat_a || d_quot.sat_b;
					two_q  <= 1'b1;
				end
				KIND_DOUBLE, KIND_LIN: begin
					re0_q  <= d_quot.qa;
					sat0_q <= d_quot.sat_a;
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid     = hold_q;
	assign result.kind      = kind_q;
	assign result.root_real = idx_q ? re1_q : re0_q;
	assign result.root_imag = idx_q ? im1_q : im0_q;
	assign result.saturated = idx_q ? sat1_q : sat0_q;
	assign result.last      = !two_q || idx_q;

endmodule
